/* sv/pte_pkg.sv */
package pte_pkg;

   // Configuration port geometry: one 32-bit register at byte address 0.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_PALETTE_COLORS = 1'b0;

   // Color counts above this select 8-bit indices.
   localparam logic [8:0] WIDE_INDEX_MIN_COLORS = 9'd16;
   localparam logic [8:0] PALETTE_COLORS_RESET = 9'd256;

   // Alpha rescale constants.
   localparam logic [7:0] ALPHA_SAT_LIMIT = 8'd128;
   localparam logic [7:0] ALPHA_MAX = 8'd255;

   // Input item codes.
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_PIXEL = 1'b1;

   typedef struct packed {
      logic        func;
      logic [7:0]  entry_index;
      logic [31:0] entry_color;
      logic [7:0]  pixel_byte;
   } pte_req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       last_of_item;
   } pte_rsp_type;

   // Rescale palette alpha by 255/128 with saturation above 128.
   function automatic logic [7:0] pte_scale_alpha(input logic [7:0] a);
      logic [15:0] prod;
      prod = {a, 8'd0} - {8'd0, a};
      if (a > ALPHA_SAT_LIMIT) begin
         return ALPHA_MAX;
      end
      return prod[14:7];
   endfunction

endpackage

/* sv/palette_texel_expander.sv */
// Palette texel expander.
// Load beats (func = 0) on the req channel write one RGBA entry of the
// palette and produce nothing on the rsp channel. Pixel beats (func = 1)
// expand one byte of indexed pixels into RGBA texels on the rsp channel.
// With more than 16 palette colors the byte is one 8-bit index (bits 3 and 4
// swapped) and gives one texel; otherwise it holds two 4-bit indices, high
// nibble first, and gives two texels, the second flagged last_of_item.
// The palette color count is set through the APB-style register at address 0.
// A pixel beat passes the issue stage, the palette read stage and the output
// register. Throughput: one beat per cycle for loads and 8-bit pixels when the
// receiver does not stall; the single palette read port reads a 4-bit pixel
// beat's two nibbles in turn. Reset clears the pipeline valid bits and sets the
// color count to 256; the palette itself holds nothing defined until entries
// are loaded. When the receiver stalls, the whole pipeline holds in place;
// req_ready drops only once the issue stage is occupied and cannot move on.
module palette_texel_expander import pte_pkg::*; #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  pte_req_type           req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output pte_rsp_type           rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int AW = $clog2(PALETTE_ENTRIES);
   localparam logic [8:0] ENTRIES_LIMIT = 9'(PALETTE_ENTRIES);

   logic [8:0]  colors_ff, colors_in;
   logic        s1_v_ff, s1_v_in;
   pte_req_type s1_item_ff, s1_item_in;
   logic        s1_phase_ff, s1_phase_in;
   logic        s2_v_ff, s2_last_ff, s2_zero_ff;
   logic        rsp_valid_ff;
   pte_rsp_type rsp_data_ff, rsp_data_in;

   logic        advance, four_mode, s1_pix, s1_split, s1_done;
   logic [7:0]  tex_idx;
   logic        tex_last, tex_zero, wr_en;
   logic [31:0] rd_word;

   // Configuration register.
   assign pready = 1'b1;

   always_comb begin
      colors_in = colors_ff;
      if (psel && penable && pwrite && paddr[2] == CSR_IDX_PALETTE_COLORS) begin
         colors_in = pwdata[8:0];
      end
   end

   assign prdata = (paddr[2] == CSR_IDX_PALETTE_COLORS) ?
                   {{(CSR_DATA_W-9){1'b0}}, colors_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         colors_ff <= PALETTE_COLORS_RESET;
      end else begin
         colors_ff <= colors_in;
      end
   end

   // Pipeline control: all stages move together when the output can take data.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign four_mode = colors_ff <= WIDE_INDEX_MIN_COLORS;
   assign s1_pix    = s1_v_ff && s1_item_ff.func == FUNC_PIXEL;
   assign s1_split  = s1_pix && four_mode && !s1_phase_ff;
   assign s1_done   = s1_v_ff && advance && !s1_split;
   assign req_ready = !s1_v_ff || s1_done;

   // Issue stage: holds the beat, and holds a 4-bit pixel beat on for its low nibble.
   always_comb begin
      s1_v_in     = s1_v_ff;
      s1_item_in  = s1_item_ff;
      s1_phase_in = s1_phase_ff;
      if (req_valid && req_ready) begin
         s1_v_in     = 1'b1;
         s1_item_in  = req_data;
         s1_phase_in = 1'b0;
      end else if (s1_done) begin
         s1_v_in = 1'b0;
      end else if (s1_split && advance) begin
         s1_phase_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff     <= 1'b0;
         s1_phase_ff <= 1'b0;
      end else begin
         s1_v_ff     <= s1_v_in;
         s1_phase_ff <= s1_phase_in;
      end
      s1_item_ff <= s1_item_in;
   end

   // Texel index: swapped 8-bit index, or one nibble in 4-bit mode.
   always_comb begin
      if (!four_mode) begin
         tex_idx = {s1_item_ff.pixel_byte[7:5], s1_item_ff.pixel_byte[3],
                    s1_item_ff.pixel_byte[4], s1_item_ff.pixel_byte[2:0]};
      end else if (!s1_phase_ff) begin
         tex_idx = {4'd0, s1_item_ff.pixel_byte[7:4]};
      end else begin
         tex_idx = {4'd0, s1_item_ff.pixel_byte[3:0]};
      end
   end

   assign tex_last = !four_mode || s1_phase_ff;
   assign tex_zero = {1'b0, tex_idx} >= ENTRIES_LIMIT;
   assign wr_en    = s1_v_ff && s1_item_ff.func == FUNC_LOAD && advance &&
                     ({1'b0, s1_item_ff.entry_index} < ENTRIES_LIMIT);

   pte_ram #(
      .WIDTH (32),
      .DEPTH (PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_item_ff.entry_index[AW-1:0]),
      .wr_data (s1_item_ff.entry_color),
      .rd_en   (advance),
      .rd_addr (tex_idx[AW-1:0]),
      .rd_data (rd_word)
   );

   // Read stage: flags that travel alongside the palette read.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (advance) begin
         s2_v_ff <= s1_pix;
      end
      if (advance) begin
         s2_last_ff <= tex_last;
         s2_zero_ff <= tex_zero;
      end
   end

   // Output stage: split the color and rescale alpha, or give zero past the palette.
   always_comb begin
      if (s2_zero_ff) begin
         rsp_data_in.red   = 8'd0;
         rsp_data_in.green = 8'd0;
         rsp_data_in.blue  = 8'd0;
         rsp_data_in.alpha = 8'd0;
      end else begin
         rsp_data_in.red   = rd_word[7:0];
         rsp_data_in.green = rd_word[15:8];
         rsp_data_in.blue  = rd_word[23:16];
         rsp_data_in.alpha = pte_scale_alpha(rd_word[31:24]);
      end
      rsp_data_in.last_of_item = s2_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s2_v_ff;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* sv/pte_ram.sv */
module pte_ram import pte_pkg::*; #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/pte_checker.sv */
module pte_checker import pte_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input pte_rsp_type           rsp_data,
   input logic                  psel,
   input logic                  penable,
   input logic                  pwrite,
   input logic [CSR_ADDR_W-1:0] paddr,
   input logic [CSR_DATA_W-1:0] pwdata,
   input logic [CSR_DATA_W-1:0] prdata,
   input logic                  pready
);

   // A stalled texel stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   // The second texel of a 4-bit pixel follows its first without a gap.
   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last_of_item |=>
      rsp_valid && rsp_data.last_of_item)
      else $error("second texel of a pixel beat missing");

   // Reset empties the pipeline and restores the color count.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid &&
      (paddr[2] != CSR_IDX_PALETTE_COLORS || prdata[8:0] == PALETTE_COLORS_RESET))
      else $error("state after reset is wrong");

   // A register write reads back.
   a_readback: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && pready && paddr[2] == CSR_IDX_PALETTE_COLORS |=>
      (paddr[2] != CSR_IDX_PALETTE_COLORS || prdata[8:0] == $past(pwdata[8:0])))
      else $error("color count does not read back");

endmodule

bind palette_texel_expander pte_checker u_pte_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .psel      (psel),
   .penable   (penable),
   .pwrite    (pwrite),
   .paddr     (paddr),
   .pwdata    (pwdata),
   .prdata    (prdata),
   .pready    (pready)
);
